// File: hdl/cwsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel speed regulator package
// Shared sizes, codes and request/result types of the wheel speed regulator.
// ----------------------------------------------------------------------------
package cwsr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SPEED_BITS  = 16;

    localparam int DUTY_W  = 12;
    localparam int GAIN_W  = 8;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W  = SPEED_BITS + GAIN_W + 2;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [DUTY_W-1:0] PERIOD_RESET = DUTY_W'(4000);
    localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(5);

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_FINISH = 3'd2,
        OP_SET    = 3'd3,
        OP_REG    = 3'd4,
        OP_FWD    = 3'd5,
        OP_BWD    = 3'd6,
        OP_STOP   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_CAL    = 3'd1,
        ST_OUT_RANGE  = 3'd2,
        ST_NO_BRACKET = 3'd3,
        ST_FULL       = 3'd4,
        ST_IGNORED    = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD = 2'd0,
        REG_LOOP_GAIN  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]            op;
        logic [DUTY_W-1:0]     entry_duty;
        logic [SPEED_BITS-1:0] entry_speed;
        logic [SPEED_BITS-1:0] target_speed;
        logic [SPEED_BITS-1:0] measured_speed;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [DUTY_W-1:0]     pwm_duty;
        logic                  forward_drive;
        logic                  backward_drive;
        logic                  pwm_enable;
        logic [SPEED_BITS-1:0] min_speed;
        logic [SPEED_BITS-1:0] max_speed;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_req_t;

endpackage
`default_nettype wire

// File: hdl/cwsr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel speed regulator channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface cwsr_cmd_if;
    logic               valid;
    logic               ready;
    cwsr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cwsr_rsp_if;
    logic                valid;
    logic                ready;
    cwsr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cwsr_cfg_if;
    logic               valid;
    logic               ready;
    cwsr_pkg::cfg_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/calibrated_wheel_speed_regulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calibrated wheel speed regulator
// Calibration table, table lookup for set speed, proportional regulation and
// direction control of one wheel motor.
// ----------------------------------------------------------------------------
// The result is registered after the request is taken; regulate passes through
// multiply, then add and clamp, and set speed may walk the table, which it reads
// one entry per cycle through its one port.
// One command at a time; the next can be taken while the last result is valid
// and leaving.
// Reset clears count, flags, duty, direction; period 4000, gain 5; table kept.
module calibrated_wheel_speed_regulator_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cwsr_cmd_if.sink        cmd,
    cwsr_rsp_if.source      rsp,
    cwsr_cfg_if.sink        cfg
);

    localparam int SB = cwsr_pkg::SPEED_BITS;
    localparam int DW = cwsr_pkg::DUTY_W;
    localparam int IW = cwsr_pkg::IDX_W;
    localparam int CW = cwsr_pkg::CNT_W;
    localparam int PW = cwsr_pkg::PROD_W;
    localparam int SW = cwsr_pkg::SUM_W;
    localparam int GW = cwsr_pkg::GAIN_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_WALK = 5'b00100,
        S_MUL  = 5'b01000,
        S_ADD  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    cwsr_pkg::in_item_t      item_reg, item_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [SB-1:0]           low_reg, low_next;
    logic [SB-1:0]           high_reg, high_next;
    logic                    cal_reg, cal_next;
    logic                    moving_reg, moving_next;
    logic [DW-1:0]           duty_reg, duty_next;
    logic [1:0]              dir_reg, dir_next;
    logic [DW-1:0]           period_reg;
    logic [GW-1:0]           gain_reg;
    logic [IW-1:0]           walk_idx_reg, walk_idx_next;
    logic [SB-1:0]           prev_speed_reg, prev_speed_next;
    logic [DW-1:0]           prev_duty_reg, prev_duty_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic                    out_valid_reg, out_valid_next;
    cwsr_pkg::out_item_t     out_data_reg, out_data_next;

    // calibration table: {duty, speed}
    logic [DW+SB-1:0]        tbl_mem [cwsr_pkg::TABLE_DEPTH];
    logic [DW+SB-1:0]        rd_data_reg;
    logic [IW-1:0]           rd_addr;
    logic                    tbl_we;
    logic [SB-1:0]           rd_speed;
    logic [DW-1:0]           rd_duty;

    logic                    cmd_accept;
    logic                    done;
    cwsr_pkg::status_t       status;
    logic signed [SB:0]      diff;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    period_ext;

    assign cmd_accept = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;

    assign rd_speed = rd_data_reg[SB-1:0];
    assign rd_duty  = rd_data_reg[DW+SB-1:SB];
    // read the entry after the one arriving, so a new pair shows every cycle
    assign rd_addr  = (state_reg == S_WALK) ? IW'(walk_idx_reg + 1'b1) : '0;
    assign tbl_we   = (state_reg == S_EXEC) && (item_reg.op == cwsr_pkg::OP_ADD) &&
                      (item_reg.entry_speed != '0) &&
                      (count_reg < CW'(cwsr_pkg::TABLE_DEPTH));

    assign diff = $signed({1'b0, item_reg.target_speed}) -
                  $signed({1'b0, item_reg.measured_speed});
    assign sum  = $signed({{(SW-DW){1'b0}}, duty_reg}) + SW'(prod_reg);
    assign period_ext = $signed({{(SW-DW){1'b0}}, period_reg});

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[count_reg[IW-1:0]] <= {item_reg.entry_duty, item_reg.entry_speed};
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        cal_next        = cal_reg;
        moving_next     = moving_reg;
        duty_next       = duty_reg;
        dir_next        = dir_reg;
        walk_idx_next   = walk_idx_reg;
        prev_speed_next = prev_speed_reg;
        prev_duty_next  = prev_duty_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        done            = 1'b0;
        status          = cwsr_pkg::ST_OK;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    item_next  = cmd.data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (item_reg.op)
                    cwsr_pkg::OP_CLEAR:
                    begin
                        count_next  = '0;
                        low_next    = '1;
                        high_next   = '0;
                        cal_next    = 1'b0;
                        duty_next   = '0;
                        moving_next = 1'b0;
                        dir_next    = 2'b00;
                        done        = 1'b1;
                    end
                    cwsr_pkg::OP_ADD:
                    begin
                        if (item_reg.entry_speed == '0)
                        begin
                            status = cwsr_pkg::ST_IGNORED;
                        end
                        else if (!tbl_we)
                        begin
                            status = cwsr_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = CW'(count_reg + 1'b1);
                            if (item_reg.entry_speed < low_reg)
                            begin
                                low_next = item_reg.entry_speed;
                            end
                            if (item_reg.entry_speed > high_reg)
                            begin
                                high_next = item_reg.entry_speed;
                            end
                        end
                        done = 1'b1;
                    end
                    cwsr_pkg::OP_FINISH:
                    begin
                        moving_next = 1'b0;
                        dir_next    = 2'b00;
                        cal_next    = 1'b1;
                        done        = 1'b1;
                    end
                    cwsr_pkg::OP_SET:
                    begin
                        if (!cal_reg)
                        begin
                            status = cwsr_pkg::ST_NOT_CAL;
                            done   = 1'b1;
                        end
                        else if (item_reg.target_speed < low_reg ||
                                 item_reg.target_speed > high_reg)
                        begin
                            status = cwsr_pkg::ST_OUT_RANGE;
                            done   = 1'b1;
                        end
                        else if (count_reg < CW'(2))
                        begin
                            status = cwsr_pkg::ST_NO_BRACKET;
                            done   = 1'b1;
                        end
                        else
                        begin
                            walk_idx_next = '0;
                            state_next    = S_WALK;
                        end
                    end
                    cwsr_pkg::OP_REG:
                    begin
                        if (!moving_reg)
                        begin
                            status = cwsr_pkg::ST_IGNORED;
                            done   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    cwsr_pkg::OP_FWD:
                    begin
                        moving_next = 1'b1;
                        dir_next    = 2'b01;
                        done        = 1'b1;
                    end
                    cwsr_pkg::OP_BWD:
                    begin
                        moving_next = 1'b1;
                        dir_next    = 2'b10;
                        done        = 1'b1;
                    end
                    default:
                    begin
                        moving_next = 1'b0;
                        dir_next    = 2'b00;
                        done        = 1'b1;
                    end
                endcase
            end
            S_WALK:
            begin
                // entry walk_idx is in rd_data_reg, entry walk_idx-1 in prev
                if (walk_idx_reg != '0 && prev_speed_reg <= item_reg.target_speed &&
                    rd_speed >= item_reg.target_speed)
                begin
                    if (prev_duty_reg <= period_reg)
                    begin
                        duty_next = prev_duty_reg;
                    end
                    done = 1'b1;
                end
                else if ({1'b0, walk_idx_reg} == CW'(count_reg - 1'b1))
                begin
                    status = cwsr_pkg::ST_NO_BRACKET;
                    done   = 1'b1;
                end
                else
                begin
                    prev_speed_next = rd_speed;
                    prev_duty_next  = rd_duty;
                    walk_idx_next   = IW'(walk_idx_reg + 1'b1);
                end
            end
            S_MUL:
            begin
                prod_next  = PW'($signed({1'b0, gain_reg})) * PW'(diff);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (sum > period_ext)
                begin
                    duty_next = period_reg;
                end
                else if (sum < 0)
                begin
                    duty_next = '0;
                end
                else
                begin
                    duty_next = sum[DW-1:0];
                end
                done = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done)
        begin
            state_next                   = S_IDLE;
            out_valid_next               = 1'b1;
            out_data_next.status         = status;
            out_data_next.pwm_duty       = duty_next;
            out_data_next.forward_drive  = dir_next[0];
            out_data_next.backward_drive = dir_next[1];
            out_data_next.pwm_enable     = moving_next;
            out_data_next.min_speed      = low_next;
            out_data_next.max_speed      = high_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            cal_reg       <= 1'b0;
            moving_reg    <= 1'b0;
            duty_reg      <= '0;
            dir_reg       <= 2'b00;
            period_reg    <= cwsr_pkg::PERIOD_RESET;
            gain_reg      <= cwsr_pkg::GAIN_RESET;
            walk_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cal_reg       <= cal_next;
            moving_reg    <= moving_next;
            duty_reg      <= duty_next;
            dir_reg       <= dir_next;
            walk_idx_reg  <= walk_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.data.index == cwsr_pkg::REG_PWM_PERIOD)
                begin
                    period_reg <= cfg.data.wdata[DW-1:0];
                end
                else if (cfg.data.index == cwsr_pkg::REG_LOOP_GAIN)
                begin
                    gain_reg <= cfg.data.wdata[GW-1:0];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        prev_speed_reg <= prev_speed_next;
        prev_duty_reg  <= prev_duty_next;
        prod_reg       <= prod_next;
        out_data_reg   <= out_data_next;
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wheel speed regulator testbench
// Drives command requests and register writes into the regulator, predicts
// every result in-line and compares it field by field. A short directed
// stimulus table runs first, then random calibration and drive sessions under
// several period and gain settings, with bursty requests and result stalls.
// ----------------------------------------------------------------------------
module tb_top;

    import cwsr_pkg::*;

    localparam int MAX_CYCLES   = 1_000_000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 125;

    typedef struct {
        in_item_t  c;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    cwsr_cmd_if cmd_ch ();
    cwsr_rsp_if rsp_ch ();
    cwsr_cfg_if cfg_ch ();

    calibrated_wheel_speed_regulator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Regulator state as the predictor sees it
    logic [DUTY_W-1:0]     cal_duty  [TABLE_DEPTH];
    logic [SPEED_BITS-1:0] cal_speed [TABLE_DEPTH];
    int                    cal_count;
    logic [SPEED_BITS-1:0] speed_lo;
    logic [SPEED_BITS-1:0] speed_hi;
    bit                    cal_done;
    bit                    wheel_on;
    logic [DUTY_W-1:0]     duty_now;
    logic [1:0]            dir_bits;
    logic [DUTY_W-1:0]     period_reg;
    logic [GAIN_W-1:0]     gain_reg;

    out_item_t expected_q [$];
    dir_row_t  rows [$];

    int  errors;
    int  sent;
    int  checked;
    int  reg_writes;
    int  cycles;
    int  burst_left;
    int  holds_done;
    int  status_hits [8];
    bit  hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic out_item_t regulator_step(in_item_t c);
        out_item_t r;
        status_t   st;
        longint    acc;
        st = ST_OK;
        case (op_t'(c.op))
            OP_CLEAR:
            begin
                cal_count = 0;
                speed_lo  = '1;
                speed_hi  = '0;
                cal_done  = 1'b0;
                duty_now  = '0;
                wheel_on  = 1'b0;
                dir_bits  = 2'b00;
            end
            OP_ADD:
            begin
                if (c.entry_speed == '0)
                    st = ST_IGNORED;
                else if (cal_count >= TABLE_DEPTH)
                    st = ST_FULL;
                else
                begin
                    cal_duty[cal_count]  = c.entry_duty;
                    cal_speed[cal_count] = c.entry_speed;
                    cal_count++;
                    if (c.entry_speed < speed_lo)
                        speed_lo = c.entry_speed;
                    if (c.entry_speed > speed_hi)
                        speed_hi = c.entry_speed;
                end
            end
            OP_FINISH:
            begin
                wheel_on = 1'b0;
                dir_bits = 2'b00;
                cal_done = 1'b1;
            end
            OP_SET:
            begin
                if (!cal_done)
                    st = ST_NOT_CAL;
                else if (c.target_speed < speed_lo || c.target_speed > speed_hi)
                    st = ST_OUT_RANGE;
                else
                begin
                    st = ST_NO_BRACKET;
                    // first adjacent pair that brackets the target wins
                    for (int i = 0; i + 1 < cal_count; i++)
                    begin
                        if (cal_speed[i] <= c.target_speed &&
                            cal_speed[i + 1] >= c.target_speed)
                        begin
                            if (cal_duty[i] <= period_reg)
                                duty_now = cal_duty[i];
                            st = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_REG:
            begin
                if (!wheel_on)
                    st = ST_IGNORED;
                else
                begin
                    acc = longint'(duty_now) + longint'(gain_reg) *
                          (longint'(c.target_speed) - longint'(c.measured_speed));
                    if (acc > longint'(period_reg))
                        acc = longint'(period_reg);
                    if (acc < 0)
                        acc = 0;
                    duty_now = DUTY_W'(acc);
                end
            end
            OP_FWD:
            begin
                wheel_on = 1'b1;
                dir_bits = 2'b01;
            end
            OP_BWD:
            begin
                wheel_on = 1'b1;
                dir_bits = 2'b10;
            end
            default:
            begin
                wheel_on = 1'b0;
                dir_bits = 2'b00;
            end
        endcase
        r.status         = st;
        r.pwm_duty       = duty_now;
        r.forward_drive  = dir_bits[0];
        r.backward_drive = dir_bits[1];
        r.pwm_enable     = wheel_on;
        r.min_speed      = speed_lo;
        r.max_speed      = speed_hi;
        return r;
    endfunction

    function automatic out_item_t make_result(status_t st, int duty, bit fwd, bit bwd,
                                              bit en, int lo, int hi);
        out_item_t r;
        r.status         = st;
        r.pwm_duty       = DUTY_W'(duty);
        r.forward_drive  = fwd;
        r.backward_drive = bwd;
        r.pwm_enable     = en;
        r.min_speed      = SPEED_BITS'(lo);
        r.max_speed      = SPEED_BITS'(hi);
        return r;
    endfunction

    function automatic in_item_t rand_cmd(op_t op);
        in_item_t c;
        c.op             = op;
        c.entry_duty     = DUTY_W'($urandom);
        c.entry_speed    = SPEED_BITS'($urandom);
        c.target_speed   = SPEED_BITS'($urandom);
        c.measured_speed = SPEED_BITS'($urandom);
        return c;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("[%0t] result %0d: %s is 0x%0h, want 0x%0h", $time, checked, field,
                 got, want);
        errors++;
    endtask

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (expected_q.size() == 0)
            begin
                $display("[%0t] result with nothing outstanding: status %0d duty 0x%0h",
                         $time, got.status, got.pwm_duty);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 16'(got.status), 16'(want.status));
                if (got.pwm_duty !== want.pwm_duty)
                    report_mismatch("pwm_duty", 16'(got.pwm_duty), 16'(want.pwm_duty));
                if (got.forward_drive !== want.forward_drive)
                    report_mismatch("forward_drive", 16'(got.forward_drive),
                                    16'(want.forward_drive));
                if (got.backward_drive !== want.backward_drive)
                    report_mismatch("backward_drive", 16'(got.backward_drive),
                                    16'(want.backward_drive));
                if (got.pwm_enable !== want.pwm_enable)
                    report_mismatch("pwm_enable", 16'(got.pwm_enable), 16'(want.pwm_enable));
                if (got.min_speed !== want.min_speed)
                    report_mismatch("min_speed", got.min_speed, want.min_speed);
                if (got.max_speed !== want.max_speed)
                    report_mismatch("max_speed", got.max_speed, want.max_speed);
                checked++;
            end
        end
    end

    // Result side: stretches of differing stall rates, long hold-off on request
    initial
    begin : rsp_stall
        int pct;
        int stretch;
        int held;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            case ($urandom_range(0, 2))
                0:       pct = 100;
                1:       pct = 60;
                default: pct = 25;
            endcase
            stretch = $urandom_range(10, 80);
            repeat (stretch)
            begin
                @(negedge clk);
                rsp_ch.ready <= ($urandom_range(0, 99) < pct);
                if (hold_req)
                    break;
            end
        end
    end

    // Offer one request in bursts; predict its result once accepted
    task automatic send_cmd(in_item_t c, bit typed = 1'b0, out_item_t want = '0);
        out_item_t pred;
        int        gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pred = regulator_step(c);
        status_hits[pred.status]++;
        expected_q.insert(expected_q.size(), typed ? want : pred);
        sent++;
        @(negedge clk);
    endtask

    // Drop the request line and hold until every result is back
    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_PWM_PERIOD)
            period_reg = val;
        else
            gain_reg = val[GAIN_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_row(op_t op, int ed, int es, int ts, int ms, bit typed = 1'b0,
                           out_item_t want = '0);
        dir_row_t r;
        r.c                = rand_cmd(op);
        r.c.entry_duty     = DUTY_W'(ed);
        r.c.entry_speed    = SPEED_BITS'(es);
        r.c.target_speed   = SPEED_BITS'(ts);
        r.c.measured_speed = SPEED_BITS'(ms);
        r.typed            = typed;
        r.want             = want;
        rows.insert(rows.size(), r);
    endtask

    // One session: optional table rebuild, then a mix of drive requests
    task automatic run_session(bit calibrate, int n_adds, int n_ops);
        in_item_t c;
        int       spd;
        int       roll;
        if (calibrate)
        begin
            send_cmd(rand_cmd(OP_CLEAR));
            spd = $urandom_range(1, 3000);
            repeat (n_adds)
            begin
                c    = rand_cmd(OP_ADD);
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    c.entry_speed = '0;
                else if (roll >= 15)
                begin
                    // ascending speeds give the lookup real brackets
                    c.entry_speed = SPEED_BITS'(spd);
                    spd += $urandom_range(1, 60000 / (n_adds + 1));
                    if (spd > 65535)
                        spd = 65535;
                end
                send_cmd(c);
            end
            send_cmd(rand_cmd(OP_FINISH));
        end
        repeat (n_ops)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                c = rand_cmd(OP_SET);
                if (cal_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    if ($urandom_range(0, 1))
                        c.target_speed = cal_speed[$urandom_range(0, cal_count - 1)];
                    else if (speed_hi >= speed_lo)
                        c.target_speed = SPEED_BITS'($urandom_range(speed_lo, speed_hi));
                end
            end
            else if (roll < 60)
            begin
                c = rand_cmd(OP_REG);
                if ($urandom_range(0, 1))
                    c.measured_speed = SPEED_BITS'(int'(c.target_speed) +
                                                   $urandom_range(0, 100) - 50);
            end
            else if (roll < 70)
                c = rand_cmd(OP_FWD);
            else if (roll < 78)
                c = rand_cmd(OP_BWD);
            else if (roll < 83)
                c = rand_cmd(OP_STOP);
            else if (roll < 91)
                c = rand_cmd(OP_ADD);
            else if (roll < 95)
                c = rand_cmd(OP_FINISH);
            else if (roll < 97)
                c = rand_cmd(OP_CLEAR);
            else
                c = rand_cmd(op_t'($urandom_range(0, 7)));
            send_cmd(c);
        end
    endtask

    initial
    begin : stimulus
        int               phase_start;
        in_item_t         c;
        logic [DUTY_W-1:0] periods [NUM_PHASES];
        logic [GAIN_W-1:0] gains   [NUM_PHASES];

        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        hold_req     = 1'b0;

        cal_count  = 0;
        speed_lo   = '1;
        speed_hi   = '0;
        cal_done   = 1'b0;
        wheel_on   = 1'b0;
        duty_now   = '0;
        dir_bits   = 2'b00;
        period_reg = PERIOD_RESET;
        gain_reg   = GAIN_RESET;

        periods = '{12'd4095, 12'd1, 12'd2048, DUTY_W'($urandom_range(2, 4094)),
                    12'd300, DUTY_W'($urandom_range(1, 4095))};
        gains   = '{8'd255, 8'd0, GAIN_W'($urandom), 8'd1, 8'd5, GAIN_W'($urandom)};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: reset state, extremes, error codes
        add_row(OP_SET, 0, 0, 100, 0, 1,
                make_result(ST_NOT_CAL, 0, 0, 0, 0, 16'hFFFF, 0));
        add_row(OP_REG, 0, 0, 65535, 0, 1,
                make_result(ST_IGNORED, 0, 0, 0, 0, 16'hFFFF, 0));
        add_row(OP_ADD, 4095, 0, 0, 0, 1,
                make_result(ST_IGNORED, 0, 0, 0, 0, 16'hFFFF, 0));
        add_row(OP_ADD, 4095, 65535, 0, 0, 1,
                make_result(ST_OK, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        add_row(OP_ADD, 0, 1, 0, 0, 1,
                make_result(ST_OK, 0, 0, 0, 0, 1, 16'hFFFF));
        add_row(OP_ADD, 100, 1000, 0, 0);
        add_row(OP_SET, 0, 0, 500, 0, 1,
                make_result(ST_NOT_CAL, 0, 0, 0, 0, 1, 16'hFFFF));
        add_row(OP_FINISH, 0, 0, 0, 0, 1,
                make_result(ST_OK, 0, 0, 0, 0, 1, 16'hFFFF));
        add_row(OP_SET, 0, 0, 0, 0, 1,
                make_result(ST_OUT_RANGE, 0, 0, 0, 0, 1, 16'hFFFF));
        add_row(OP_SET, 0, 0, 65535, 0);
        add_row(OP_SET, 0, 0, 500, 0);
        add_row(OP_ADD, 3000, 2000, 0, 0);
        add_row(OP_SET, 0, 0, 1500, 0);
        add_row(OP_FWD, 0, 0, 0, 0);
        add_row(OP_REG, 0, 0, 65535, 0, 1,
                make_result(ST_OK, 4000, 1, 0, 1, 1, 16'hFFFF));
        add_row(OP_REG, 0, 0, 0, 65535, 1,
                make_result(ST_OK, 0, 1, 0, 1, 1, 16'hFFFF));
        add_row(OP_REG, 0, 0, 40, 20);
        add_row(OP_BWD, 0, 0, 0, 0);
        add_row(OP_STOP, 0, 0, 0, 0);
        add_row(OP_CLEAR, 0, 0, 0, 0, 1,
                make_result(ST_OK, 0, 0, 0, 0, 16'hFFFF, 0));
        add_row(OP_FINISH, 0, 0, 0, 0, 1,
                make_result(ST_OK, 0, 0, 0, 0, 16'hFFFF, 0));
        add_row(OP_SET, 0, 0, 0, 0, 1,
                make_result(ST_OUT_RANGE, 0, 0, 0, 0, 16'hFFFF, 0));
        add_row(OP_ADD, 50, 10, 0, 0);
        add_row(OP_FINISH, 0, 0, 0, 0);
        add_row(OP_SET, 0, 0, 10, 0, 1,
                make_result(ST_NO_BRACKET, 0, 0, 0, 0, 10, 10));

        foreach (rows[i])
            send_cmd(rows[i].c, rows[i].typed, rows[i].want);

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiesce();
            write_reg(REG_PWM_PERIOD, periods[p]);
            write_reg(REG_LOOP_GAIN, {(CFG_DATA_W - GAIN_W)'($urandom), gains[p]});
            if (p == 1 || p == 4)
                hold_req = 1'b1;
            phase_start = sent;
            // carry state over first, so a lowered period meets an old duty
            run_session(1'b0, 0, $urandom_range(4, 10));
            if (p == 2 || p == 5)
                run_session(1'b1, TABLE_DEPTH + 2, $urandom_range(10, 20));
            while (sent - phase_start < PHASE_ITEMS)
                run_session(1'b1, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1)
                                                               : $urandom_range(2, 10),
                            $urandom_range(8, 30));
            // leave the wheel running, duty pushed toward full, for the next setting
            send_cmd(rand_cmd(OP_FWD));
            c                = rand_cmd(OP_REG);
            c.target_speed   = '1;
            c.measured_speed = '0;
            send_cmd(c);
        end

        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands (%0d from the directed table) over %0d register writes,",
                 sent, rows.size(), reg_writes);
        $display("%0d results compared; ok %0d, uncal %0d, range %0d, bracket %0d,",
                 checked, status_hits[ST_OK], status_hits[ST_NOT_CAL],
                 status_hits[ST_OUT_RANGE], status_hits[ST_NO_BRACKET]);
        $display("full %0d, ign %0d", status_hits[ST_FULL], status_hits[ST_IGNORED]);
        if (errors == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/cwsr_pkg.sv
hdl/cwsr_ifs.sv
hdl/calibrated_wheel_speed_regulator_unit.sv
tb/sv/tb_top.sv
